// ----- rtl/core/dtdl_pkg.sv -----
// dtdl_pkg: shared types and constants for the dead-time delay line
// no dependencies; used by dtdl_ram, dead_time_delay_line and the testbench
`default_nettype none

package dtdl_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int TIME_W    = 32;

	// total of accumulator and dead time carries one extra bit
	localparam int TOTAL_W   = TIME_W + 1;

	// restoring division over the 33-bit total, one quotient bit per cycle
	localparam int DIV_STEPS = TOTAL_W;
	localparam int STEP_W    = 6;

	localparam logic [TIME_W-1:0] STEP_TIME_RST = 32'h0001_0000;

	typedef enum logic [0:0] {
		REG_DELAY_TIME = 1'b0,
		REG_STEP_TIME  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_WRITE,
		ST_DSET,
		ST_DIV,
		ST_DFIN,
		ST_RD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/dead_time_delay_line.sv -----
// dead_time_delay_line: dead-time element over a ring buffer of signed samples
// depends on dtdl_pkg and dtdl_ram
//
//   channel  | direction | tdata / payload              | handshake
//   s_axis   | in        | [31:0] sample                | tvalid/tready
//   m_axis   | out       | [31:0] delayed_sample        | tvalid/tready
//   cfg      | in        | cfg_index, [31:0] cfg_data   | cfg_valid/cfg_ready
//
// one shared 33-bit subtractor runs all time arithmetic but the sum of accumulator and
// dead time, under a small sequencer; while the total exceeds the step, each write of the
// item takes one step off it, and past DEPTH writes a restoring division does the rest
// after reset a clearing pass writes zeros over every buffer word
// s_axis is ready only when idle; a held result in m_axis stalls only the final move
`default_nettype none

module dead_time_delay_line #(
	parameter int DEPTH = dtdl_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [dtdl_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] sample
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic      [dtdl_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] delayed_sample
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [dtdl_pkg::TIME_W-1:0] cfg_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = dtdl_pkg::TOTAL_W;
	localparam int SW = dtdl_pkg::TIME_W;
	localparam int DW = dtdl_pkg::DATA_W;
	localparam logic [IW-1:0] IDX_TOP   = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	dtdl_pkg::state_t st_q, st_d;

	logic [SW-1:0] delay_q, step_q, acc_q;
	logic [TW-1:0] total_q, dvd_q;
	logic [SW-1:0] rem_q;
	logic [DW-1:0] x_q;
	logic [IW-1:0] idx_q, qmod_q;
	logic [CW-1:0] cnt_q;
	logic [dtdl_pkg::STEP_W-1:0] bit_q;
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;

	// shared subtractor
	logic [TW-1:0] sub_a, sub_b;
	logic [TW:0]   sub_y;
	logic          borrow;

	logic [SW-1:0] s_eff;
	logic [TW-1:0] trial;
	logic          gt_step, quo_bit;
	logic [IW:0]   qdbl, qnext;
	logic [IW-1:0] idx_dec, idx_fin;
	logic          in_acc, out_free;

	logic          ram_we, ram_re;
	logic [DW-1:0] ram_wdata, ram_rdata;

	// a zero step time behaves as the smallest step
	assign s_eff = (step_q == '0) ? SW'(1) : step_q;

	assign sub_y  = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = sub_y[TW];

	assign trial   = {rem_q, dvd_q[TW-1]};
	assign gt_step = !borrow && (sub_y[TW-1:0] != '0);
	assign quo_bit = !borrow;

	// quotient kept modulo DEPTH as it is built
	assign qdbl  = {qmod_q, quo_bit};
	assign qnext = (qdbl >= DEPTH_X) ? qdbl - DEPTH_X : qdbl;

	assign idx_dec = (idx_q == '0) ? IDX_TOP : idx_q - IW'(1);
	assign idx_fin = (idx_q >= qmod_q) ? idx_q - qmod_q
		: IW'({1'b0, idx_q} + DEPTH_X - {1'b0, qmod_q});

	assign s_axis_tready = (st_q == dtdl_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	always_comb begin
		st_d = st_q;
		case (st_q)
			dtdl_pkg::ST_CLR: begin
				if (idx_q == '0) st_d = dtdl_pkg::ST_IDLE;
			end
			dtdl_pkg::ST_IDLE: begin
				if (in_acc) st_d = dtdl_pkg::ST_WRITE;
			end
			dtdl_pkg::ST_WRITE: begin
				if (!gt_step) st_d = dtdl_pkg::ST_RD;
				else if (cnt_q == DEPTH_CNT) st_d = dtdl_pkg::ST_DSET;
			end
			dtdl_pkg::ST_DSET: st_d = dtdl_pkg::ST_DIV;
			dtdl_pkg::ST_DIV: begin
				if (bit_q == dtdl_pkg::STEP_W'(dtdl_pkg::DIV_STEPS - 1)) st_d = dtdl_pkg::ST_DFIN;
			end
			dtdl_pkg::ST_DFIN: st_d = dtdl_pkg::ST_RD;
			dtdl_pkg::ST_RD:   st_d = dtdl_pkg::ST_OUT;
			dtdl_pkg::ST_OUT: begin
				if (out_free) st_d = dtdl_pkg::ST_IDLE;
			end
			default: st_d = dtdl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sub_a     = total_q;
		sub_b     = {1'b0, s_eff};
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = x_q;
		case (st_q)
			dtdl_pkg::ST_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			dtdl_pkg::ST_WRITE: begin
				ram_we = gt_step && (cnt_q != DEPTH_CNT);
			end
			dtdl_pkg::ST_DSET: begin
				sub_b = TW'(1);
			end
			dtdl_pkg::ST_DIV: begin
				sub_a = trial;
			end
			dtdl_pkg::ST_DFIN: begin
				// minus all ones is plus one modulo 2^33
				sub_a = {1'b0, rem_q};
				sub_b = '1;
			end
			dtdl_pkg::ST_RD: begin
				ram_re = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= dtdl_pkg::ST_CLR;
			delay_q     <= '0;
			step_q      <= dtdl_pkg::STEP_TIME_RST;
			acc_q       <= '0;
			idx_q       <= IDX_TOP;
			cnt_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				case (dtdl_pkg::reg_idx_t'(cfg_index))
					dtdl_pkg::REG_DELAY_TIME: delay_q <= cfg_data;
					dtdl_pkg::REG_STEP_TIME:  step_q  <= cfg_data;
					default:                  delay_q <= delay_q;
				endcase
			end
			if (st_q == dtdl_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				dtdl_pkg::ST_CLR: idx_q <= idx_dec;
				dtdl_pkg::ST_IDLE: cnt_q <= '0;
				dtdl_pkg::ST_WRITE: begin
					if (!gt_step) begin
						acc_q <= total_q[SW-1:0];
					end else if (cnt_q != DEPTH_CNT) begin
						idx_q <= idx_dec;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				dtdl_pkg::ST_DSET: bit_q <= '0;
				dtdl_pkg::ST_DIV:  bit_q <= bit_q + dtdl_pkg::STEP_W'(1);
				dtdl_pkg::ST_DFIN: begin
					acc_q <= sub_y[SW-1:0];
					idx_q <= idx_fin;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			dtdl_pkg::ST_IDLE: begin
				if (in_acc) begin
					x_q     <= s_axis_tdata;
					total_q <= {1'b0, acc_q} + {1'b0, delay_q};
				end
			end
			dtdl_pkg::ST_WRITE: begin
				if (gt_step && cnt_q != DEPTH_CNT) total_q <= sub_y[TW-1:0];
			end
			dtdl_pkg::ST_DSET: begin
				dvd_q  <= sub_y[TW-1:0];
				rem_q  <= '0;
				qmod_q <= '0;
			end
			dtdl_pkg::ST_DIV: begin
				rem_q  <= quo_bit ? sub_y[SW-1:0] : trial[SW-1:0];
				dvd_q  <= {dvd_q[TW-2:0], 1'b0};
				qmod_q <= qnext[IW-1:0];
			end
			dtdl_pkg::ST_OUT: begin
				if (out_free) out_data_q <= ram_rdata;
			end
			default: x_q <= x_q;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	dtdl_ram #(
		.DEPTH(DEPTH),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

// ----- rtl/core/dtdl_ram.sv -----
// dtdl_ram: single write port, single registered read port sample buffer
// depends on dtdl_pkg for the data width and the default depth
`default_nettype none

module dtdl_ram #(
	parameter int DEPTH = dtdl_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [dtdl_pkg::DATA_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [dtdl_pkg::DATA_W-1:0] rdata
);

	logic [dtdl_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [dtdl_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- tb/sv/dead_time_delay_line_test.sv -----
// dead_time_delay_line_test: self-checking bench for the dead-time delay line
// depends on dtdl_pkg and dead_time_delay_line; a scoreboard class predicts every delayed sample
// covers directed corner settings, then random phases with random stalls on both streams
`default_nettype none

module dead_time_delay_line_test;

	localparam int RING_DEPTH  = dtdl_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 828;

	class delay_line_scoreboard;
		logic [dtdl_pkg::DATA_W-1:0] ring [RING_DEPTH];
		int unsigned                 wr_ptr;
		logic [dtdl_pkg::TIME_W-1:0] acc;
		logic [dtdl_pkg::TIME_W-1:0] dead_time;
		logic [dtdl_pkg::TIME_W-1:0] period;
		logic [dtdl_pkg::DATA_W-1:0] expected_q [$];
		int                          errors;
		int                          samples_in;
		int                          full_fills;
		int                          idle_steps;
		int                          settings;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_ptr     = RING_DEPTH - 1;
			acc        = '0;
			dead_time  = '0;
			period     = dtdl_pkg::STEP_TIME_RST;
			errors     = 0;
			samples_in = 0;
			full_fills = 0;
			idle_steps = 0;
			settings   = 0;
		endfunction

		function void set_reg(dtdl_pkg::reg_idx_t idx, logic [dtdl_pkg::TIME_W-1:0] value);
			if (idx == dtdl_pkg::REG_DELAY_TIME) begin
				dead_time = value;
			end else begin
				period = value;
				settings++;
			end
		endfunction

		// one input transaction: run the time bookkeeping and queue the word it exposes
		function void note_sample(logic [dtdl_pkg::DATA_W-1:0] x);
			logic [63:0] per;
			logic [63:0] total;
			logic [63:0] passes;
			logic [63:0] fill;
			int unsigned idx;
			int unsigned back;
			per    = (period == '0) ? 64'd1 : {32'd0, period};
			total  = {32'd0, acc} + {32'd0, dead_time};
			passes = (total > per) ? (total - 64'd1) / per : 64'd0;
			fill   = (passes < RING_DEPTH) ? passes : 64'(RING_DEPTH);
			idx    = wr_ptr;
			for (int k = 0; k < fill; k++) begin
				ring[idx] = x;
				idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
			end
			back   = 32'(passes % RING_DEPTH);
			wr_ptr = (wr_ptr + RING_DEPTH - back) % RING_DEPTH;
			acc    = dtdl_pkg::TIME_W'(total - passes * per);
			if (passes >= RING_DEPTH) full_fills++;
			if (passes == 0) idle_steps++;
			samples_in++;
			expected_q.push_back(ring[wr_ptr]);
		endfunction

		function void check_result(logic [dtdl_pkg::DATA_W-1:0] got);
			logic [dtdl_pkg::DATA_W-1:0] want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected delayed_sample %h, expected none, actual %h",
					$time, got, got);
			end else begin
				want = expected_q.pop_front();
				if (want !== got) begin
					errors++;
					$display("%0t: delayed_sample mismatch, expected %h, actual %h",
						$time, want, got);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	wire                           s_axis_tready;
	logic [dtdl_pkg::DATA_W-1:0]   s_axis_tdata = '0;
	wire                           m_axis_tvalid;
	logic                          m_axis_tready = 1'b1;
	wire  [dtdl_pkg::DATA_W-1:0]   m_axis_tdata;
	logic                          cfg_valid = 1'b0;
	wire                           cfg_ready;
	logic [0:0]                    cfg_index = dtdl_pkg::REG_DELAY_TIME;
	logic [dtdl_pkg::TIME_W-1:0]   cfg_data = '0;

	delay_line_scoreboard sb;
	int                   send_mode = 1;
	int                   recv_mode = 1;
	int                   recv_stall = 0;
	int                   cycles = 0;

	dead_time_delay_line #(.DEPTH(RING_DEPTH)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// 0: no idling, 1: uniform 0..18, 2: mostly back to back
	function automatic int draw_wait(int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 18);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check each output transaction, then stall for a drawn count
	always @(posedge clk) begin
		int w;
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
			w = draw_wait(recv_mode);
			if (w == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				recv_stall <= w;
			end
		end else if (!m_axis_tready) begin
			if (recv_stall <= 1) m_axis_tready <= 1'b1;
			else recv_stall <= recv_stall - 1;
		end
	end

	task automatic send_sample(logic [dtdl_pkg::DATA_W-1:0] x);
		int gap;
		gap = draw_wait(send_mode);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(x);
	endtask

	// hold the input off until every queued result has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task automatic apply_setting(logic [dtdl_pkg::TIME_W-1:0] dly,
		logic [dtdl_pkg::TIME_W-1:0] per);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= dtdl_pkg::REG_DELAY_TIME;
		cfg_data  <= dly;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(dtdl_pkg::REG_DELAY_TIME, dly);
		cfg_index <= dtdl_pkg::REG_STEP_TIME;
		cfg_data  <= per;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(dtdl_pkg::REG_STEP_TIME, per);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [dtdl_pkg::DATA_W-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic pick_setting(output logic [dtdl_pkg::TIME_W-1:0] dly,
		output logic [dtdl_pkg::TIME_W-1:0] per);
		logic [63:0] wide;
		case ($urandom_range(0, 9))
			0: begin
				dly = $urandom;
				per = $urandom;
			end
			1: begin
				per = '0;
				dly = $urandom_range(0, 40);
			end
			2: begin
				per = 32'd1;
				dly = $urandom_range(0, 80);
			end
			3: begin
				dly = 32'hFFFF_FFFF;
				per = $urandom;
			end
			4: begin
				per = 32'hFFFF_FFFF;
				dly = $urandom;
			end
			default: begin
				// whole steps plus a fraction keeps the pass count small but varied
				per  = $urandom_range(1, 32'h0004_0000);
				wide = 64'(per) * $urandom_range(0, 6) + $urandom_range(0, per);
				dly  = wide[31:0];
			end
		endcase
	endtask

	initial begin
		int sent;
		int phase_len;
		int hold_at;
		logic [dtdl_pkg::TIME_W-1:0] dly;
		logic [dtdl_pkg::TIME_W-1:0] per;

		sb = new();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: total never exceeds the step, nothing written
		send_mode = 1;
		recv_mode = 1;
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);

		// three whole steps of dead time
		apply_setting(32'h0003_0000, 32'h0001_0000);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h5555_5555);
		send_sample(32'hAAAA_AAAA);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);

		// half step: writes on every other sample
		apply_setting(32'h0000_8000, 32'h0001_0000);
		send_sample(32'h1234_5678);
		send_sample(32'h9ABC_DEF0);
		send_sample(32'h0000_0001);
		send_sample(32'h0000_0002);

		// zero step time acts as the smallest period
		apply_setting(32'd5, 32'd0);
		send_sample(32'hDEAD_BEEF);
		send_sample(32'h0F0F_0F0F);
		send_sample(32'hF0F0_F0F0);

		// pass count far beyond the depth, every word overwritten
		apply_setting(32'hFFFF_FFFF, 32'd1);
		send_sample(32'hC001_D00D);
		send_sample(32'h3141_5926);

		// total of accumulator and dead time needs the carry bit
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h0000_00FF);
		send_sample(32'hFF00_0000);
		send_sample(32'h00FF_FF00);

		// dead time zero against the largest step
		apply_setting(32'h0000_0000, 32'hFFFF_FFFF);
		send_sample(32'h7FFF_0000);
		send_sample(32'h0000_8000);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick_setting(dly, per);
			apply_setting(dly, per);
			send_mode = $urandom_range(0, 2);
			recv_mode = $urandom_range(0, 2);
			phase_len = $urandom_range(40, 130);
			if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
			hold_at   = $urandom_range(0, phase_len - 1);
			for (int i = 0; i < phase_len; i++) begin
				if (i == hold_at) drain();
				send_sample(pick_sample());
			end
			sent += phase_len;
		end

		drain();
		repeat (150) @(posedge clk);

		$display("%0d samples over %0d step settings; %0d filled the whole ring, %0d wrote nothing",
			sb.samples_in, sb.settings, sb.full_fills, sb.idle_steps);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/dtdl_pkg.sv
rtl/core/dtdl_ram.sv
rtl/core/dead_time_delay_line.sv
tb/sv/dead_time_delay_line_test.sv
